### src/psp_pkg.sv
// Shared widths and item types for the point-to-segment proximity test.
package psp_pkg;
  localparam int CoordW = 24;
  localparam int DiffW  = CoordW + 1;
  localparam int ProdW  = 2 * DiffW;
  localparam int SumW   = ProdW + 2;
  localparam int LFrac  = 16;
  localparam int QW     = LFrac + 1;
  localparam int MulW   = QW + 1 + DiffW;
  localparam int AbsW   = DiffW + 3;
  localparam int DistW  = 27;
  localparam int FifoDepth = 4;
  localparam int FifoAw    = 2;

  typedef struct packed {
    logic                      span;
    logic [2:0][DiffW-1:0]     rel;
    logic [2:0][DiffW-1:0]     dl;
    logic [SumW-1:0]           num;
    logic [SumW-1:0]           len2;
  } item_t;

  typedef struct packed {
    logic push;
    logic full;
  } fifo_ctl_t;
endpackage

### src/psp_front.sv
// Front part: differences, dot products and span classification.
module psp_front import psp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  logic signed [CoordW-1:0] q [3],
  input  logic signed [CoordW-1:0] a [3],
  input  logic signed [CoordW-1:0] b [3],
  output logic                     push,
  output item_t                    item
);
  logic v1_r, v2_r, v3_r, v4_r;
  logic signed [DiffW-1:0] rel1_r [3], dl1_r [3];
  logic signed [DiffW-1:0] rel2_r [3], dl2_r [3];
  logic signed [DiffW-1:0] rel3_r [3], dl3_r [3];
  logic signed [ProdW-1:0] sq_r [3], pr_r [3];
  logic signed [SumW-1:0]  len2_r, num_r;
  item_t item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
    end else begin
      v1_r <= accept; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      rel1_r[k] <= DiffW'(q[k]) - DiffW'(a[k]);
      dl1_r[k]  <= DiffW'(b[k]) - DiffW'(a[k]);
      sq_r[k]   <= dl1_r[k] * dl1_r[k];
      pr_r[k]   <= rel1_r[k] * dl1_r[k];
      rel2_r[k] <= rel1_r[k];
      dl2_r[k]  <= dl1_r[k];
      rel3_r[k] <= rel2_r[k];
      dl3_r[k]  <= dl2_r[k];
    end
    len2_r <= SumW'(sq_r[0]) + SumW'(sq_r[1]) + SumW'(sq_r[2]);
    num_r  <= SumW'(pr_r[0]) + SumW'(pr_r[1]) + SumW'(pr_r[2]);
    item_r.span <= (len2_r != '0) && !num_r[SumW-1] && (num_r <= len2_r);
    item_r.num  <= num_r;
    item_r.len2 <= len2_r;
    for (int k = 0; k < 3; k++) begin
      item_r.rel[k] <= rel3_r[k];
      item_r.dl[k]  <= dl3_r[k];
    end
  end

  assign push = v4_r;
  assign item = item_r;
endmodule

### src/psp_fifo.sv
// Short queue between the front and back parts.
module psp_fifo import psp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  fifo_ctl_t ctl_in,
  input  item_t     wdata,
  output logic      full,
  output logic      rvalid,
  output item_t     rdata
);
  item_t mem_r [FifoDepth];
  logic [FifoAw-1:0] wp_r, rp_r;
  logic [FifoAw:0]   cnt_r;
  logic              pop;

  assign pop    = cnt_r != '0;
  assign rvalid = pop;
  assign full   = cnt_r == (FifoAw+1)'(FifoDepth);
  assign rdata  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (ctl_in.push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (ctl_in.push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (FifoAw+1)'(ctl_in.push) - (FifoAw+1)'(pop);
    end
  end
endmodule

### src/psp_back.sv
// Back part: restoring divider pipeline, residuals and L1 distance.
module psp_back import psp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_v,
  input  item_t            in_item,
  input  logic [DistW-1:0] tol,
  output logic             out_valid,
  output logic             out_hit,
  output logic             out_in_span,
  output logic [DistW-1:0] out_distance
);
  logic              dv_r   [QW];
  item_t             dit_r  [QW];
  logic [SumW-1:0]   drem_r [QW];
  logic [QW-1:0]     dq_r   [QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < QW; j++) dv_r[j] <= 1'b0;
    end else begin
      dv_r[0] <= in_v;
      for (int j = 1; j < QW; j++) dv_r[j] <= dv_r[j-1];
    end
  end

  // One quotient bit per stage; the first stage yields the integer bit.
  always_ff @(posedge clk) begin
    logic [SumW-1:0] r;
    for (int j = 0; j < QW; j++) begin
      if (j == 0) r = in_item.num;
      else        r = {drem_r[j-1][SumW-2:0], 1'b0};
      if (j == 0) begin
        dit_r[0] <= in_item;
        if (r >= in_item.len2) begin
          drem_r[0] <= r - in_item.len2; dq_r[0] <= QW'(1);
        end else begin
          drem_r[0] <= r; dq_r[0] <= '0;
        end
      end else begin
        dit_r[j] <= dit_r[j-1];
        if (r >= dit_r[j-1].len2) begin
          drem_r[j] <= r - dit_r[j-1].len2; dq_r[j] <= {dq_r[j-1][QW-2:0], 1'b1};
        end else begin
          drem_r[j] <= r; dq_r[j] <= {dq_r[j-1][QW-2:0], 1'b0};
        end
      end
    end
  end

  logic mv_r, av_r;
  logic signed [MulW-1:0]  prod_r [3];
  logic signed [DiffW-1:0] mrel_r [3];
  logic                    mspan_r, aspan_r;
  logic [AbsW-1:0]         abs_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0; av_r <= 1'b0; out_valid <= 1'b0;
    end else begin
      mv_r <= dv_r[QW-1]; av_r <= mv_r; out_valid <= av_r;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [MulW-1:0] sh;
    logic signed [AbsW-1:0] r;
    logic [AbsW+1:0]        sum;
    for (int k = 0; k < 3; k++) begin
      prod_r[k] <= $signed({1'b0, dq_r[QW-1]}) * $signed(dit_r[QW-1].dl[k]);
      mrel_r[k] <= $signed(dit_r[QW-1].rel[k]);
    end
    mspan_r <= dit_r[QW-1].span;
    for (int k = 0; k < 3; k++) begin
      sh = prod_r[k] >>> LFrac;
      r  = AbsW'(mrel_r[k]) - AbsW'(sh);
      abs_r[k] <= r[AbsW-1] ? AbsW'(-r) : AbsW'(r);
    end
    aspan_r <= mspan_r;
    sum = (AbsW+2)'(abs_r[0]) + (AbsW+2)'(abs_r[1]) + (AbsW+2)'(abs_r[2]);
    if (!aspan_r) begin
      out_distance <= '0; out_in_span <= 1'b0; out_hit <= 1'b0;
    end else if (sum > (AbsW+2)'({DistW{1'b1}})) begin
      out_distance <= '1; out_in_span <= 1'b1; out_hit <= {DistW{1'b1}} < tol;
    end else begin
      out_distance <= DistW'(sum); out_in_span <= 1'b1;
      out_hit <= DistW'(sum) < tol;
    end
  end
endmodule

### src/point_segment_proximity_test_top.sv
// Top level of the point-to-segment proximity test.
// Usage: drive the nine coordinates on in_* and pulse start; an item is taken
// at each edge with start high and busy low. Coordinates are signed with eight
// fractional bits. Each item gives one result, shown for one cycle with
// out_valid high: out_in_span, out_distance (L1 residual, saturated) and
// out_hit (in span and distance below pick_tolerance).
// Throughput is one item per clock. The projection parameter is formed one bit
// per stage by the 17-stage restoring divider.
// busy rises only if the internal queue fills, which the back part never
// allows since it drains one item every cycle that the queue is not empty.
// The receiver cannot stall: results are presented once and not held.
// pick_tolerance sits at byte address 0 of the APB port and resets to 0, so
// nothing hits after reset. Reset clears all pipeline valid bits and the queue.
module point_segment_proximity_test_top import psp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [CoordW-1:0] in_query_x,
  input  logic signed [CoordW-1:0] in_query_y,
  input  logic signed [CoordW-1:0] in_query_z,
  input  logic signed [CoordW-1:0] in_p1_x,
  input  logic signed [CoordW-1:0] in_p1_y,
  input  logic signed [CoordW-1:0] in_p1_z,
  input  logic signed [CoordW-1:0] in_p2_x,
  input  logic signed [CoordW-1:0] in_p2_y,
  input  logic signed [CoordW-1:0] in_p2_z,
  output logic                     out_valid,
  output logic                     out_hit,
  output logic                     out_in_span,
  output logic [DistW-1:0]         out_distance,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  logic [DistW-1:0] tol_r;
  logic             accept, fe_push, fifo_full, fifo_v;
  item_t            fe_item, fifo_item;
  fifo_ctl_t        fctl;
  logic signed [CoordW-1:0] qv [3], av [3], bv [3];

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : 32'(tol_r);

  always_ff @(posedge clk) begin
    if (!rst_n) tol_r <= '0;
    else if (psel && penable && pwrite && !paddr[2]) tol_r <= pwdata[DistW-1:0];
  end

  assign busy   = fifo_full;
  assign accept = start && !busy;
  assign qv = '{in_query_x, in_query_y, in_query_z};
  assign av = '{in_p1_x, in_p1_y, in_p1_z};
  assign bv = '{in_p2_x, in_p2_y, in_p2_z};

  psp_front u_front (
    .clk(clk), .rst_n(rst_n), .accept(accept), .q(qv), .a(av), .b(bv),
    .push(fe_push), .item(fe_item)
  );

  assign fctl.push = fe_push;
  assign fctl.full = fifo_full;

  psp_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .ctl_in(fctl), .wdata(fe_item),
    .full(fifo_full), .rvalid(fifo_v), .rdata(fifo_item)
  );

  psp_back u_back (
    .clk(clk), .rst_n(rst_n), .in_v(fifo_v), .in_item(fifo_item), .tol(tol_r),
    .out_valid(out_valid), .out_hit(out_hit), .out_in_span(out_in_span),
    .out_distance(out_distance)
  );

`ifndef NO_ASSERTIONS
  a_hit_needs_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_in_span) else $error("hit without span");
  a_dist_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_span |-> out_distance == '0) else $error("distance not zero");
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy) else $error("queue filled");
  a_push_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##4 fe_push) else $error("front lost an item");
`endif
endmodule
